[sv/ecmu_pkg.sv]
// ----------------------------------------------------------------------------
// ecmu_pkg: shared definitions for the edge coverage map update unit
// Stream field widths, scramble shifts, the register map, register reset values and command codes.
// ----------------------------------------------------------------------------
package ecmu_pkg;

  // Map size default (power of two)
  localparam int unsigned MapEntriesDef = 65536;

  // Stream field widths
  localparam int unsigned AddrW      = 64;
  localparam int unsigned ReadIdxW   = 16;
  localparam int unsigned MapIdxW    = 16;
  localparam int unsigned HitW       = 8;
  localparam int unsigned InTdataW   = AddrW + ReadIdxW;   // 80 bits, 10 bytes
  localparam int unsigned OutTdataW  = MapIdxW + HitW;     // 24 bits, 3 bytes

  // Scramble shift amounts
  localparam int unsigned ScrShiftR  = 4;
  localparam int unsigned ScrShiftL  = 8;

  // Configuration port
  localparam int unsigned ApbAddrW   = 4;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned RatioW     = 17;
  localparam logic [RatioW-1:0] RatioRst = RatioW'(65536);

  // Register word indexes (paddr[3:2])
  typedef enum logic [1:0] {
    REG_VALIDATING = 2'd0,
    REG_CHECKPOINT = 2'd1,
    REG_INST_RATIO = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_e;

  // Stream command codes (s_axis_tuser)
  localparam logic CmdLog  = 1'b0;
  localparam logic CmdRead = 1'b1;

endpackage

[sv/edge_coverage_map_update_unit.sv]
// ----------------------------------------------------------------------------
// edge_coverage_map_update_unit: edge coverage bitmap with 8-bit hit counters
// Scrambles executed block addresses, bumps the counter of the edge taken and
// serves counter reads, all from one synchronous map memory.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the whole map to zero, one entry per cycle, and
// s_axis_tready stays low until the sweep ends (register writes are taken
// meanwhile). After that it takes one transaction per cycle: a command is
// accepted and, for a log or a read, the map is read at that edge; when stage 1
// advances, a log's counter is incremented and written back and the result is
// placed in the output register, which drives m_axis. A write from the previous
// item to the same entry is forwarded, so back-to-back hits on one edge count
// correctly. One map read per item sets the one-per-cycle rate, and a stalled
// result holds off the input once the stage and output register are full.
// Every command yields exactly one result; logs that are disabled or not
// instrumented return all zeros.
module edge_coverage_map_update_unit #(
  parameter int unsigned MAP_ENTRIES = ecmu_pkg::MapEntriesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Command stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ecmu_pkg::InTdataW-1:0]   s_axis_tdata,  // [63:0] block_address,
                                                         // [79:64] read_index
  input  logic                            s_axis_tuser,  // [0] command
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ecmu_pkg::OutTdataW-1:0]  m_axis_tdata,  // [15:0] map_index,
                                                         // [23:16] hit_count
  output logic                            m_axis_tuser,  // [0] counted
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ecmu_pkg::ApbAddrW-1:0]   paddr,
  input  logic [ecmu_pkg::ApbDataW-1:0]   pwdata,
  output logic [ecmu_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);
  import ecmu_pkg::*;

  localparam int unsigned IdxW = $clog2(MAP_ENTRIES);
  localparam int unsigned CmpW = (IdxW > RatioW) ? IdxW : RatioW;
  // Index mask, also keeps a non power-of-two map inside its depth
  localparam logic [IdxW-1:0] IdxMask = IdxW'(MAP_ENTRIES - 1);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_LOG,
    KIND_READ
  } kind_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic              validating_q;
  logic              checkpoint_q;
  logic [RatioW-1:0] ratio_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      validating_q <= 1'b0;
      checkpoint_q <= 1'b0;
      ratio_q      <= RatioRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_VALIDATING: validating_q <= pwdata[0];
        REG_CHECKPOINT: checkpoint_q <= pwdata[0];
        REG_INST_RATIO: ratio_q      <= pwdata[RatioW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_VALIDATING: prdata = ApbDataW'(validating_q);
      REG_CHECKPOINT: prdata = ApbDataW'(checkpoint_q);
      REG_INST_RATIO: prdata = ApbDataW'(ratio_q);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Map memory and clearing sweep
  // --------------------------------------------------------------------------
  logic [HitW-1:0] map_mem [MAP_ENTRIES];
  logic [HitW-1:0] rdata_q;
  logic            clear_q;
  logic [IdxW-1:0] clr_addr_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [HitW-1:0] mem_wdata;
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= map_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q    <= 1'b1;
      clr_addr_q <= '0;
    end else if (clear_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == IdxMask) begin
        clear_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Front end: scramble, edge index, instrumentation check
  // --------------------------------------------------------------------------
  logic [AddrW-1:0] in_addr;
  logic [AddrW-1:0] mixed;
  logic [IdxW-1:0]  loc;
  logic [IdxW-1:0]  prev_q;
  logic [IdxW-1:0]  edge_idx;
  logic [IdxW-1:0]  rd_idx;
  logic             log_on;
  logic             instrumented;
  kind_e            in_kind;
  logic [IdxW-1:0]  in_idx;
  logic             in_acc;

  assign in_addr      = s_axis_tdata[AddrW-1:0];
  assign mixed        = (in_addr >> ScrShiftR) ^ (in_addr << ScrShiftL);
  assign loc          = mixed[IdxW-1:0] & IdxMask;
  assign edge_idx     = (loc ^ prev_q) & IdxMask;
  assign rd_idx       = IdxW'(s_axis_tdata[AddrW +: ReadIdxW]) & IdxMask;
  assign log_on       = !validating_q && checkpoint_q;
  assign instrumented = CmpW'(loc) < CmpW'(ratio_q);

  always_comb begin
    if (s_axis_tuser == CmdRead) begin
      in_kind = KIND_READ;
      in_idx  = rd_idx;
    end else if (log_on && instrumented) begin
      in_kind = KIND_LOG;
      in_idx  = edge_idx;
    end else begin
      in_kind = KIND_NONE;
      in_idx  = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: waits for read data, then updates the counter
  // --------------------------------------------------------------------------
  logic            s1_valid_q;
  kind_e           s1_kind_q;
  logic [IdxW-1:0] s1_idx_q;
  logic            s1_adv;
  logic            wr_valid_q;
  logic [IdxW-1:0] wr_addr_q;
  logic [HitW-1:0] wr_data_q;
  logic [HitW-1:0] cur_val;
  logic [HitW-1:0] inc_val;
  logic            s1_log_wr;

  assign s1_adv        = s1_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !clear_q && (!s1_valid_q || s1_adv);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s1_log_wr     = s1_adv && (s1_kind_q == KIND_LOG);

  // Forward the last counter write over the stale memory read
  assign cur_val = (wr_valid_q && (wr_addr_q == s1_idx_q)) ? wr_data_q : rdata_q;
  assign inc_val = cur_val + 1'b1;

  // Memory port selection
  assign mem_re    = in_acc && (in_kind != KIND_NONE);
  assign mem_raddr = in_idx;
  assign mem_we    = clear_q || s1_log_wr;
  assign mem_waddr = clear_q ? clr_addr_q : s1_idx_q;
  assign mem_wdata = clear_q ? '0 : inc_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_kind_q  <= KIND_NONE;
      prev_q     <= '0;
      wr_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        s1_kind_q  <= in_kind;
        if (in_kind == KIND_LOG) begin
          prev_q <= (loc >> 1) & IdxMask;
        end
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_log_wr) begin
        wr_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_idx_q <= in_idx;
    end
    if (s1_log_wr) begin
      wr_addr_q <= s1_idx_q;
      wr_data_q <= inc_val;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic               out_valid_q;
  logic               out_counted_q;
  logic [MapIdxW-1:0] out_idx_q;
  logic [HitW-1:0]    out_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      case (s1_kind_q)
        KIND_LOG: begin
          out_counted_q <= 1'b1;
          out_idx_q     <= MapIdxW'(s1_idx_q);
          out_hit_q     <= inc_val;
        end
        KIND_READ: begin
          out_counted_q <= 1'b0;
          out_idx_q     <= MapIdxW'(s1_idx_q);
          out_hit_q     <= cur_val;
        end
        default: begin
          out_counted_q <= 1'b0;
          out_idx_q     <= '0;
          out_hit_q     <= '0;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_hit_q, out_idx_q};
  assign m_axis_tuser  = out_counted_q;

endmodule
